[rtl/stt_pkg.sv]
package stt_pkg;

  localparam int SLOTS  = 16;
  // handles are 4 bits wide, so at most 16 slots are ever used
  localparam int USABLE = (SLOTS < 16) ? SLOTS : 16;
  localparam int SLOT_W = 4;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_SCAN = 2'd2;

  localparam logic [1:0] MODE_ONESHOT  = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;

  localparam logic [2:0] KIND_ADDED   = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_DELETED = 3'd2;
  localparam logic [2:0] KIND_EXPIRED = 3'd3;
  localparam logic [2:0] KIND_NONE    = 3'd4;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [31:0]       now;
    logic [1:0]        mode;
    logic [31:0]       period;
    logic [SLOT_W-1:0] slot;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic [2:0]        kind;
    logic              last;
  } out_t;

  // decoded command handed from front to back
  typedef struct packed {
    logic [1:0]        op;
    logic [31:0]       now;
    logic [31:0]       deadline;
    logic [1:0]        mode;
    logic [31:0]       period;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage

[rtl/stt_front.sv]
module stt_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  stt_pkg::in_t  in_data,
  output logic          push,
  output stt_pkg::cmd_t push_data,
  input  logic          q_full
);

  logic known_op;

  // opcode 3 is swallowed here and never reaches the back end
  assign known_op = (in_data.opcode == stt_pkg::OP_ADD) ||
                    (in_data.opcode == stt_pkg::OP_DEL) ||
                    (in_data.opcode == stt_pkg::OP_SCAN);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && known_op;

  always_comb begin
    push_data.op       = in_data.opcode;
    push_data.now      = in_data.now;
    push_data.deadline = in_data.now + in_data.period;
    push_data.mode     = in_data.mode;
    push_data.period   = in_data.period;
    push_data.slot     = in_data.slot;
  end

endmodule

[rtl/stt_fifo.sv]
module stt_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  stt_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output stt_pkg::cmd_t head
);

  stt_pkg::cmd_t                   mem_r [stt_pkg::Q_DEPTH];
  logic [stt_pkg::Q_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [stt_pkg::Q_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [stt_pkg::Q_CW-1:0]        cnt_r, cnt_nxt;

  assign full       = (cnt_r == stt_pkg::Q_CW'(stt_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  function automatic logic [stt_pkg::Q_AW-1:0] ptr_inc(input logic [stt_pkg::Q_AW-1:0] p);
    ptr_inc = (p == stt_pkg::Q_AW'(stt_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/stt_back.sv]
module stt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  stt_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output stt_pkg::out_t out_data
);

  localparam int W = stt_pkg::SLOT_W;
  localparam logic [W-1:0] LAST_IDX = W'(stt_pkg::USABLE - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t                      state_r, state_nxt;
  logic [stt_pkg::USABLE-1:0]  occ_r, occ_nxt;
  logic [stt_pkg::USABLE-1:0]  armed_r, armed_nxt;
  logic [W-1:0]                idx_r, idx_nxt;
  logic                        pend_v_r, pend_v_nxt;
  logic [W-1:0]                pend_slot_r, pend_slot_nxt;
  logic [31:0]                 scan_now_r, scan_now_nxt;
  logic                        out_valid_r, out_valid_nxt;
  stt_pkg::out_t               out_data_r, out_data_nxt;

  logic [1:0]                  mode_r     [stt_pkg::USABLE];
  logic [31:0]                 deadline_r [stt_pkg::USABLE];
  logic [31:0]                 reload_r   [stt_pkg::USABLE];

  logic         wr_en, wr_full;
  logic [W-1:0] wr_idx;
  logic [31:0]  wr_deadline;

  logic         out_free;
  logic         free_found;
  logic [W-1:0] free_idx;
  logic [31:0]  since;
  logic         hit;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < stt_pkg::USABLE; i++) begin
      if (!occ_r[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = W'(i);
      end
    end
  end

  // wrap-safe "now at or after deadline"
  assign since = scan_now_r - deadline_r[idx_r];
  assign hit   = occ_r[idx_r] && armed_r[idx_r] && !since[31];

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    armed_nxt     = armed_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    scan_now_nxt  = scan_now_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_full       = 1'b0;
    wr_idx        = idx_r;
    wr_deadline   = scan_now_r + reload_r[idx_r];

    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_head.op)
            stt_pkg::OP_ADD: begin
              out_valid_nxt = 1'b1;
              if (free_found) begin
                occ_nxt[free_idx]   = 1'b1;
                armed_nxt[free_idx] = 1'b1;
                wr_en        = 1'b1;
                wr_full      = 1'b1;
                wr_idx       = free_idx;
                wr_deadline  = q_head.deadline;
                out_data_nxt = '{slot_out: free_idx, kind: stt_pkg::KIND_ADDED, last: 1'b1};
              end else begin
                out_data_nxt = '{slot_out: '0, kind: stt_pkg::KIND_FULL, last: 1'b1};
              end
            end
            stt_pkg::OP_DEL: begin
              out_valid_nxt = 1'b1;
              if ({1'b0, q_head.slot} < (W+1)'(stt_pkg::USABLE)) begin
                occ_nxt[q_head.slot]   = 1'b0;
                armed_nxt[q_head.slot] = 1'b0;
              end
              out_data_nxt = '{slot_out: q_head.slot, kind: stt_pkg::KIND_DELETED,
                               last: 1'b1};
            end
            stt_pkg::OP_SCAN: begin
              scan_now_nxt = q_head.now;
              idx_nxt      = '0;
              pend_v_nxt   = 1'b0;
              state_nxt    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // a hit with a result still held back must hand that result over first
        if (!(hit && pend_v_r) || out_free) begin
          if (hit) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{slot_out: pend_slot_r, kind: stt_pkg::KIND_EXPIRED,
                                last: 1'b0};
            end
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = idx_r;
            armed_nxt[idx_r] = 1'b0;
            if (mode_r[idx_r] == stt_pkg::MODE_ONESHOT) begin
              occ_nxt[idx_r] = 1'b0;
            end else if (mode_r[idx_r] == stt_pkg::MODE_PERIODIC) begin
              armed_nxt[idx_r] = 1'b1;
              wr_en = 1'b1;
            end
          end
          idx_nxt = idx_r + 1'b1;
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pend_v_r) begin
            out_data_nxt = '{slot_out: pend_slot_r, kind: stt_pkg::KIND_EXPIRED, last: 1'b1};
          end else begin
            out_data_nxt = '{slot_out: '0, kind: stt_pkg::KIND_NONE, last: 1'b1};
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      armed_r     <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      pend_slot_r <= '0;
      scan_now_r  <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      armed_r     <= armed_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_slot_r <= pend_slot_nxt;
      scan_now_r  <= scan_now_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      deadline_r[wr_idx] <= wr_deadline;
      if (wr_full) begin
        mode_r[wr_idx]   <= q_head.mode;
        reload_r[wr_idx] <= q_head.period;
      end
    end
  end

endmodule

[rtl/software_timer_table.sv]
// Add and delete: the item is queued, then its result is registered; one item per cycle
// while the output is not stalled and no scan runs. Scan: the item is picked up, then
// one slot per cycle over all 16 slots, set by the single deadline compare, then a close.
// A stalled output holds the scan on the next expired slot.
// Reset (rst_n low, synchronous): every slot free and disarmed, queue and output empty.
module software_timer_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  stt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output stt_pkg::out_t out_data
);

  logic          push, q_full, q_pop, q_valid;
  stt_pkg::cmd_t push_data, q_head;

  stt_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  stt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/stt_checker.sv]
module stt_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input stt_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == stt_pkg::KIND_ADDED ||
                  out_data.kind == stt_pkg::KIND_DELETED ||
                  out_data.kind == stt_pkg::KIND_FULL ||
                  out_data.kind == stt_pkg::KIND_NONE) |-> out_data.last)
    else $error("single result item without last");

  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == stt_pkg::KIND_FULL ||
                  out_data.kind == stt_pkg::KIND_NONE) |-> out_data.slot_out == '0)
    else $error("full or none result names a slot");

  // a scan's expired results are ascending, so a non-final one is never slot 15
  a_expired_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.kind == stt_pkg::KIND_EXPIRED && !out_data.last
    |-> out_data.slot_out != '1)
    else $error("expired result after the top slot");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);

[tb/sv/stt_checker.sv]
`timescale 1ns / 1ps

module stt_scoreboard
  import stt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   mismatches,
  output int   pending
);

  // shadow copy of the timer table
  logic        occupied  [USABLE];
  logic        armed     [USABLE];
  logic [1:0]  slot_mode [USABLE];
  logic [31:0] deadline  [USABLE];
  logic [31:0] reload    [USABLE];

  out_t owed_q[$];

  task automatic owe(input logic [SLOT_W-1:0] s, input logic [2:0] k, input logic l);
    out_t r;
    r.slot_out = s;
    r.kind     = k;
    r.last     = l;
    owed_q.push_back(r);
  endtask

  task automatic run_timer_cmd(input in_t cmd);
    logic [USABLE-1:0] fired;
    logic              found;
    logic [31:0]       elapsed;
    int                i;
    int                top_hit;
    fired   = '0;
    found   = 1'b0;
    top_hit = -1;
    case (cmd.opcode)
      OP_ADD: begin
        for (i = 0; i < USABLE; i++) begin
          if (!found && !occupied[i]) begin
            found        = 1'b1;
            occupied[i]  = 1'b1;
            armed[i]     = 1'b1;
            slot_mode[i] = cmd.mode;
            deadline[i]  = cmd.now + cmd.period;
            reload[i]    = cmd.period;
            owe(SLOT_W'(i), KIND_ADDED, 1'b1);
          end
        end
        if (!found) owe('0, KIND_FULL, 1'b1);
      end
      OP_DEL: begin
        if (cmd.slot < USABLE) begin
          occupied[cmd.slot] = 1'b0;
          armed[cmd.slot]    = 1'b0;
        end
        owe(cmd.slot, KIND_DELETED, 1'b1);
      end
      OP_SCAN: begin
        for (i = 0; i < USABLE; i++) begin
          if (occupied[i] && armed[i]) begin
            // wrap-safe "now at or after deadline"
            elapsed = cmd.now - deadline[i];
            if (!elapsed[31]) begin
              fired[i] = 1'b1;
              top_hit  = i;
              armed[i] = 1'b0;
              if (slot_mode[i] == MODE_ONESHOT) begin
                occupied[i] = 1'b0;
              end else if (slot_mode[i] == MODE_PERIODIC) begin
                armed[i]    = 1'b1;
                deadline[i] = cmd.now + reload[i];
              end
            end
          end
        end
        if (top_hit < 0) begin
          owe('0, KIND_NONE, 1'b1);
        end else begin
          for (i = 0; i < USABLE; i++) begin
            if (fired[i]) owe(SLOT_W'(i), KIND_EXPIRED, i == top_hit);
          end
        end
      end
      default: ;  // unused opcode: no result
    endcase
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      mismatches = 0;
      pending    = 0;
      owed_q.delete();
      for (int i = 0; i < USABLE; i++) begin
        occupied[i] = 1'b0;
        armed[i]    = 1'b0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected item slot %0d kind %0d last %0d", $realtime,
                     out_data.slot_out, out_data.kind, out_data.last);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (out_data.slot_out !== want.slot_out || out_data.kind !== want.kind ||
              out_data.last !== want.last) begin
            if (mismatches < 10)
              $display("%0t: expected slot %0d kind %0d last %0d, got slot %0d kind %0d last %0d",
                       $realtime, want.slot_out, want.kind, want.last,
                       out_data.slot_out, out_data.kind, out_data.last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) run_timer_cmd(in_data);
      pending = owed_q.size();
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import stt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] MODE_ONCE = 2'd2;
  localparam logic [1:0] MODE_ONCE_ALT = 2'd3;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int mismatches;
  int pending;
  int cyc = 0;
  int idle_pct = 6;

  software_timer_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  stt_scoreboard checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls now and then, never inside the quiet window
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > 3000 && cyc < 5000) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 6);
    end
  end

  function automatic in_t mk(input logic [1:0] op, input logic [31:0] now,
                             input logic [1:0] mode, input logic [31:0] period,
                             input logic [SLOT_W-1:0] slot);
    in_t it;
    it.opcode = op;
    it.now    = now;
    it.mode   = mode;
    it.period = period;
    it.slot   = slot;
    return it;
  endfunction

  task automatic send(input in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    in_t         it;
    logic [31:0] tick;
    int          n;
    int          r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, wrap of deadlines, every mode, full table, big scan
    send(mk(OP_SCAN, 32'h0, 2'd0, 32'h0, 4'd0));
    send(mk(OP_DEL, 32'h0, 2'd0, 32'h0, 4'd15));  // slot already free
    send(mk(OP_ADD, 32'hFFFF_FFFF, MODE_ONESHOT, 32'h0, 4'd0));
    send(mk(OP_ADD, 32'hFFFF_FFFE, MODE_PERIODIC, 32'd5, 4'd0));
    send(mk(OP_ADD, 32'h0, MODE_ONCE, 32'hFFFF_FFFF, 4'd0));
    send(mk(OP_ADD, 32'h7FFF_FFFF, MODE_ONCE_ALT, 32'h8000_0000, 4'd0));
    send(mk(OP_SCAN, 32'hFFFF_FFFF, 2'd0, 32'h0, 4'd0));
    send(mk(OP_SCAN, 32'd3, 2'd0, 32'h0, 4'd0));
    send(mk(OP_UNUSED, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF, 4'd15));
    for (int i = 0; i < 13; i++)
      send(mk(OP_ADD, 32'd100, i[0] ? MODE_PERIODIC : MODE_ONESHOT, 32'h0, 4'd0));
    send(mk(OP_ADD, 32'd100, MODE_ONESHOT, 32'd1, 4'd0));  // table is full
    send(mk(OP_SCAN, 32'd100, 2'd0, 32'h0, 4'd0));
    send(mk(OP_DEL, 32'd100, 2'd0, 32'h0, 4'd2));

    // random: ticks mostly creep forward so timers actually come due
    tick = 32'd200;
    n = 0;
    while (n < 350) begin
      idle_pct = (n >= 100 && n < 200) ? 0 : 6;
      if ($urandom_range(19) == 0) tick = $urandom();
      else tick = tick + $urandom_range(40);
      it.now    = tick;
      it.mode   = 2'($urandom_range(3));
      it.period = $urandom();
      it.slot   = SLOT_W'($urandom_range(15));
      r = $urandom_range(99);
      if (r < 30) begin
        it.opcode = OP_ADD;
        r = $urandom_range(9);
        it.mode = (r < 4) ? MODE_ONESHOT : (r < 8) ? MODE_PERIODIC :
                  (r == 8) ? MODE_ONCE : MODE_ONCE_ALT;
        r = $urandom_range(19);
        if (r < 17) it.period = $urandom_range(60);
        else if (r == 17) it.period = 32'h7FFF_FFF0 + $urandom_range(31);
      end else if (r < 45) begin
        it.opcode = OP_DEL;
      end else if (r < 97) begin
        it.opcode = OP_SCAN;
      end else begin
        it.opcode = OP_UNUSED;
      end
      send(it);
      if (it.opcode != OP_UNUSED) n++;
      if (n == 250 && it.opcode != OP_UNUSED) begin
        // let the block drain completely before going on
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("** software_timer_table: PASSED **");
    end else begin
      $display("** software_timer_table: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** software_timer_table: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_fifo.sv
rtl/stt_back.sv
rtl/software_timer_table.sv
rtl/stt_checker.sv
tb/sv/stt_checker.sv
tb/sv/tb.sv
